// File: src/cbsf_pkg.sv
// shared constants and types of the cubic bezier segment flattener
package cbsf_pkg;

  localparam int COORD_BITS    = 11;
  localparam int MAX_STEPS     = 64;
  localparam int MESH_BITS     = 7;
  localparam logic [MESH_BITS-1:0] MESH_RESET = 7'd16;
  localparam int STEP_BITS     = $clog2(MAX_STEPS + 1);
  localparam int SQ_BITS       = $clog2(MAX_STEPS * MAX_STEPS + 1);
  localparam int CUBE_BITS     = $clog2(MAX_STEPS * MAX_STEPS * MAX_STEPS + 1);
  localparam int ACC_BITS      = COORD_BITS + CUBE_BITS;
  localparam int MAC_TERMS     = 4;
  localparam int MAC_SEL_BITS  = $clog2(MAC_TERMS);
  localparam int DIV_STEPS     = COORD_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);
  localparam int IN_DATA_BITS  = ((8 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_CUBE,
    S_CHECK,
    S_ADV,
    S_WGT,
    S_MAC,
    S_DIV,
    S_EMIT,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic                    load;
    logic                    sqr;
    logic                    cube;
    logic                    adv;
    logic                    wgt;
    logic                    mac;
    logic [MAC_SEL_BITS-1:0] mac_sel;
    logic                    div;
    logic                    emit;
    logic                    fin;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic out_free;
  } sts_t;

endpackage

// File: src/cbsf_datapath.sv
// datapath: mesh register, bernstein weights, multiply-accumulate, divider, output register
module cbsf_datapath
  import cbsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  input  logic                     cfg_valid,
  input  logic [MESH_BITS-1:0]     cfg_data,
  input  logic [IN_DATA_BITS-1:0]  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_DATA_BITS-1:0] out_data,
  output logic                     out_last
);

  logic [MESH_BITS-1:0]  mesh_r;
  logic [STEP_BITS-1:0]  n_clamp;
  logic [STEP_BITS-1:0]  n_r;
  logic [STEP_BITS-1:0]  k_r, u_r;
  logic [SQ_BITS-1:0]    k2_r, u2_r;
  logic [CUBE_BITS-1:0]  k3_r, u3_r;
  logic [CUBE_BITS-1:0]  w1_r, w2_r;
  logic [CUBE_BITS-1:0]  den_r;
  logic [COORD_BITS-1:0] px_r [MAC_TERMS];
  logic [COORD_BITS-1:0] py_r [MAC_TERMS];
  logic [ACC_BITS-1:0]   acc_x_r, acc_y_r;
  logic [ACC_BITS-1:0]   ds_r;
  logic [COORD_BITS-1:0] q_x_r, q_y_r;
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                  out_last_r;
  logic [CUBE_BITS-1:0]  wsel;
  logic [ACC_BITS-1:0]   prod_x, prod_y;
  logic                  ge_x, ge_y;
  logic                  out_free;

  // zero steps behaves as one, large counts saturate
  always_comb begin
    priority if (mesh_r == '0) begin
      n_clamp = STEP_BITS'(1);
    end else if (mesh_r > MESH_BITS'(MAX_STEPS)) begin
      n_clamp = STEP_BITS'(MAX_STEPS);
    end else begin
      n_clamp = STEP_BITS'(mesh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_r <= MESH_RESET;
    end else if (cfg_valid) begin
      mesh_r <= cfg_data;
    end
  end

  always_comb begin
    unique case (cmd.mac_sel)
      2'd0:    wsel = u3_r;
      2'd1:    wsel = w1_r;
      2'd2:    wsel = w2_r;
      default: wsel = k3_r;
    endcase
  end

  assign prod_x = ACC_BITS'(px_r[cmd.mac_sel]) * ACC_BITS'(wsel);
  assign prod_y = ACC_BITS'(py_r[cmd.mac_sel]) * ACC_BITS'(wsel);
  assign ge_x   = acc_x_r >= ds_r;
  assign ge_y   = acc_y_r >= ds_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAC_TERMS; i++) begin
        px_r[i] <= in_data[2*i*COORD_BITS +: COORD_BITS];
        py_r[i] <= in_data[(2*i+1)*COORD_BITS +: COORD_BITS];
      end
      n_r  <= n_clamp;
      u_r  <= n_clamp;
      k_r  <= '0;
      k2_r <= '0;
      k3_r <= '0;
    end
    if (cmd.sqr) begin
      u2_r <= SQ_BITS'(n_r) * SQ_BITS'(n_r);
    end
    if (cmd.cube) begin
      u3_r  <= CUBE_BITS'(u2_r) * CUBE_BITS'(u_r);
      den_r <= CUBE_BITS'(u2_r) * CUBE_BITS'(u_r);
    end
    // step k up and u down by forward differences of squares and cubes
    if (cmd.adv) begin
      k_r  <= k_r + STEP_BITS'(1);
      k2_r <= k2_r + SQ_BITS'({k_r, 1'b0}) + SQ_BITS'(1);
      k3_r <= k3_r + CUBE_BITS'(3 * k2_r) + CUBE_BITS'(3 * k_r) + CUBE_BITS'(1);
      u_r  <= u_r - STEP_BITS'(1);
      u2_r <= u2_r - SQ_BITS'({u_r, 1'b0}) + SQ_BITS'(1);
      u3_r <= u3_r - CUBE_BITS'(3 * u2_r) + CUBE_BITS'(3 * u_r) - CUBE_BITS'(1);
    end
    if (cmd.wgt) begin
      w1_r    <= CUBE_BITS'(3 * u2_r * k_r);
      w2_r    <= CUBE_BITS'(3 * u_r * k2_r);
      acc_x_r <= '0;
      acc_y_r <= '0;
      ds_r    <= ACC_BITS'(den_r) << (COORD_BITS - 1);
    end
    if (cmd.mac) begin
      acc_x_r <= acc_x_r + prod_x;
      acc_y_r <= acc_y_r + prod_y;
    end
    // restoring division, one quotient bit a cycle, msb first
    if (cmd.div) begin
      acc_x_r <= ge_x ? acc_x_r - ds_r : acc_x_r;
      acc_y_r <= ge_y ? acc_y_r - ds_r : acc_y_r;
      q_x_r   <= {q_x_r[COORD_BITS-2:0], ge_x};
      q_y_r   <= {q_y_r[COORD_BITS-2:0], ge_y};
      ds_r    <= ds_r >> 1;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r    <= q_x_r;
      out_y_r    <= q_y_r;
      out_last_r <= 1'b0;
    end else if (cmd.fin) begin
      out_x_r    <= px_r[MAC_TERMS-1];
      out_y_r    <= py_r[MAC_TERMS-1];
      out_last_r <= 1'b1;
    end
  end

  assign sts.more     = ({1'b0, k_r} + (STEP_BITS+1)'(1)) < {1'b0, n_r};
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_data  = OUT_DATA_BITS'({out_y_r, out_x_r});
  assign out_last  = out_last_r;

endmodule

// File: src/cbsf_ctrl.sv
// controller: sequences setup, per-point weights, accumulate, divide and emit
module cbsf_ctrl
  import cbsf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t                  state_r, state_nxt;
  logic [MAC_SEL_BITS-1:0] mac_cnt_r, mac_cnt_nxt;
  logic [DIV_CNT_BITS-1:0] div_cnt_r, div_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      mac_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      mac_cnt_r <= mac_cnt_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    mac_cnt_nxt = mac_cnt_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    cmd.mac_sel = mac_cnt_r;
    in_ready    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQR;
        end
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.more ? S_ADV : S_FINAL;
      end
      S_ADV: begin
        cmd.adv   = 1'b1;
        state_nxt = S_WGT;
      end
      S_WGT: begin
        cmd.wgt     = 1'b1;
        mac_cnt_nxt = '0;
        state_nxt   = S_MAC;
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (mac_cnt_r == MAC_SEL_BITS'(MAC_TERMS - 1)) begin
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end else begin
          mac_cnt_nxt = mac_cnt_r + MAC_SEL_BITS'(1);
        end
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (div_cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_BITS'(1);
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // the output register must never be overwritten while it still holds a point that has not been taken
  a_write_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.fin) |-> sts.out_free)
    else $error("output written while occupied");

  a_load_starts_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_SQR))
    else $error("segment load not followed by setup");

  a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r <= DIV_CNT_BITS'(DIV_STEPS - 1)))
    else $error("divider step count out of range");

  a_final_after_points: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_CHECK) && !sts.more) |=> (state_r == S_FINAL))
    else $error("end point not emitted after interior points");

endmodule

// File: src/cubic_bezier_segment_flattener.sv
// top level of the cubic bezier segment flattener
// One request carries a cubic segment (start, two control points, end); the block answers
// with N points, N the mesh step count (0 counts as 1, above 64 as 64): B(k/N) for
// k = 1..N-1, each coordinate floor-divided exactly from the value scaled by N^3, then the
// end point itself with tlast set. Setup loads the segment and forms N^2 and N^3; each
// interior point runs check, advance, weights, four-term multiply-accumulate, 11-step
// restoring divide and emit, and the end point runs check and final. The divider, one
// quotient bit per cycle, sets the point rate unless the output stalls the emit. The next
// segment is taken once the end point sits in the output register, even before collection.
module cubic_bezier_segment_flattener
  import cbsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [MESH_BITS-1:0]     cfg_data,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // start_x, start_y, ctrl_one_x, ctrl_one_y, ctrl_two_x, ctrl_two_y, finish_x, finish_y
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // point_x, point_y, zero fill
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  output logic                     out_tlast
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cbsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbsf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule
